FILE: hw/rtl/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg: shared types and constants for barometer reading compensation
// Register indexes, sequencer opcodes and fixed formula constants.
// ----------------------------------------------------------------------------
package brc_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AC1_AC2  = 3'd0,
        REG_AC3_AC4  = 3'd1,
        REG_AC5_AC6  = 3'd2,
        REG_B1_B2    = 3'd3,
        REG_MC_MD    = 3'd4,
        REG_OSS      = 3'd5
    } cfg_reg_t;

    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] B4_BIAS   = 32'd32768;
    localparam logic [31:0] B7_SCALE  = 32'd50000;
    localparam logic [31:0] P_C1      = 32'd3038;
    localparam logic [31:0] P_C2_NEG  = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_C3      = 32'd3791;

    // divider request / response between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

    typedef enum logic [5:0] {
        S_IDLE,
        // temperature
        S_T0, S_T1, S_T2, S_T3, S_TW, S_T4,
        // pressure
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_P10, S_P11, S_P12, S_PW, S_P13, S_P14, S_P15, S_P16, S_P17, S_P18,
        S_OUT
    } seq_state_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

FILE: hw/rtl/brc_divider.sv
// ----------------------------------------------------------------------------
// brc_divider: unsigned 32-bit restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module brc_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  brc_pkg::div_req_t req,
    output brc_pkg::div_rsp_t rsp
);
    import brc_pkg::*;

    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without busy");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg > 6'd1 |=> busy_reg)
        else $error("divider stopped early");
`endif

endmodule

FILE: hw/rtl/barometer_reading_compensation.sv
// ----------------------------------------------------------------------------
// barometer_reading_compensation: integer compensation of barometer readings
// Temperature and pressure results are computed step by step on one shared
// 32x32 multiplier and the restoring divider.
// A new transaction is taken only back in idle, after the previous result has
// moved to the output register; a stalled result holds the sequencer only once
// the next one is ready.
// Reset clears control state and kept B5 to 0.
// ----------------------------------------------------------------------------
module barometer_reading_compensation
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [18:0] raw_reading,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [31:0] true_value,
    output logic        divide_error
);
    import brc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken.
    // ------------------------------------------------------------------
    logic [31:0] ac1_ac2_reg, ac3_ac4_reg, ac5_ac6_reg, b1_b2_reg, mc_md_reg;
    logic [1:0]  oss_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_ac2_reg <= 32'd26804152;
            ac3_ac4_reg <= 32'd3352395749;
            ac5_ac6_reg <= 32'd2146785905;
            b1_b2_reg   <= 32'd405667844;
            mc_md_reg   <= 32'd3724086068;
            oss_reg     <= 2'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_AC1_AC2: ac1_ac2_reg <= cfg_data;
                REG_AC3_AC4: ac3_ac4_reg <= cfg_data;
                REG_AC5_AC6: ac5_ac6_reg <= cfg_data;
                REG_B1_B2:   b1_b2_reg   <= cfg_data;
                REG_MC_MD:   mc_md_reg   <= cfg_data;
                REG_OSS:     oss_reg     <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    // Coefficients widened to 32 bits: AC4, AC5 and AC6 zero-extended, the rest sign-extended
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(ac1_ac2_reg[31:16]);
    assign ac2 = sx16(ac1_ac2_reg[15:0]);
    assign ac3 = sx16(ac3_ac4_reg[31:16]);
    assign ac4 = {16'd0, ac3_ac4_reg[15:0]};
    assign ac5 = {16'd0, ac5_ac6_reg[31:16]};
    assign ac6 = {16'd0, ac5_ac6_reg[15:0]};
    assign b1  = sx16(b1_b2_reg[31:16]);
    assign b2  = sx16(b1_b2_reg[15:0]);
    assign mc  = sx16(mc_md_reg[31:16]);
    assign md  = sx16(mc_md_reg[15:0]);

    // ------------------------------------------------------------------
    // Sequencer state and working registers
    // ------------------------------------------------------------------
    seq_state_t  state_reg, state_next;
    logic        kind_reg, kind_next;
    logic [31:0] up_reg, up_next;      // raw reading (masked for temperature)
    logic [31:0] b5_reg, b5_next;      // kept across transactions
    logic [31:0] acc_reg, acc_next;    // product of the shared multiplier
    logic [31:0] r0_reg, r0_next;      // x1 / b6
    logic [31:0] r1_reg, r1_next;      // sq / b3
    logic [31:0] r2_reg, r2_next;      // x2 / x1 / x3 / b4
    logic [31:0] r3_reg, r3_next;      // b3 / p
    logic        neg_reg, neg_next;    // quotient sign / b7 split flag
    logic        ov_reg, ov_next;      // output valid
    logic [31:0] val_reg, val_next;
    logic        err_reg, err_next;
    // output register, parted from the working registers
    logic        res_kind_reg, res_kind_next;
    logic [31:0] res_val_reg, res_val_next;
    logic        res_err_reg, res_err_next;

    // shared multiplier operands (one 32x32 low-half product)
    logic [31:0] ma, mb;
    logic [31:0] mprod;
    assign mprod = ma * mb;

    div_req_t dreq;
    div_rsp_t drsp;

    brc_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        asr = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] absv(input logic [31:0] x);
        absv = x[31] ? (32'd0 - x) : x;
    endfunction

    logic [31:0] den_t;
    assign den_t = r0_reg + md;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        up_next       = up_reg;
        b5_next       = b5_reg;
        acc_next      = acc_reg;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        r2_next       = r2_reg;
        r3_next       = r3_reg;
        neg_next      = neg_reg;
        ov_next       = ov_reg;
        val_next      = val_reg;
        err_next      = err_reg;
        res_kind_next = res_kind_reg;
        res_val_next  = res_val_reg;
        res_err_next  = res_err_reg;
        ma            = '0;
        mb            = '0;
        dreq          = '0;

        // drop the result once taken
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    up_next    = kind ? {13'd0, raw_reading} : {16'd0, raw_reading[15:0]};
                    state_next = kind ? S_P0 : S_T0;
                end
            end
            // ---- temperature ----
            S_T0:
            begin
                ma = up_reg - ac6; mb = ac5;
                acc_next = mprod[31:0];
                state_next = S_T1;
            end
            S_T1:
            begin
                r0_next = asr(acc_reg, 5'd15);     // x1
                state_next = S_T2;
            end
            S_T2:
            begin
                // den = x1 + md; zero divisor ends here
                if (den_t == 32'd0)
                begin
                    val_next = '0; err_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num   = absv({mc[20:0], 11'd0});
                    dreq.den   = absv(den_t);
                    neg_next   = mc[20] ^ den_t[31];
                    state_next = S_TW;
                end
            end
            S_TW:
            begin
                if (drsp.done)
                begin
                    r1_next = neg_reg ? (32'd0 - drsp.quo) : drsp.quo;
                    state_next = S_T3;
                end
            end
            S_T3:
            begin
                b5_next = r0_reg + r1_reg;
                state_next = S_T4;
            end
            S_T4:
            begin
                val_next = asr(b5_reg + 32'd8, 5'd4);
                err_next = 1'b0;
                state_next = S_OUT;
            end
            // ---- pressure ----
            S_P0:
            begin
                r0_next = b5_reg - B6_OFFSET;       // b6
                state_next = S_P1;
            end
            S_P1:
            begin
                ma = r0_reg; mb = r0_reg;
                acc_next = mprod[31:0];
                state_next = S_P2;
            end
            S_P2:
            begin
                r1_next = asr(acc_reg, 5'd12);      // sq
                ma = ac2; mb = r0_reg;
                acc_next = mprod[31:0];
                state_next = S_P3;
            end
            S_P3:
            begin
                r2_next = asr(acc_reg, 5'd11);      // x2
                ma = b2; mb = r1_reg;
                acc_next = mprod[31:0];
                state_next = S_P4;
            end
            S_P4:
            begin
                // x3 = x1 + x2, then b3 (kept in r3 until b4 frees r1)
                r3_next = asr((({ac1[29:0], 2'b00} + asr(acc_reg, 5'd11) + r2_reg)
                          << oss_reg) + 32'd2, 5'd2);
                ma = ac3; mb = r0_reg;
                acc_next = mprod[31:0];
                state_next = S_P5;
            end
            S_P5:
            begin
                r2_next = asr(acc_reg, 5'd13);      // x1
                ma = b1; mb = r1_reg;
                acc_next = mprod[31:0];
                state_next = S_P6;
            end
            S_P6:
            begin
                r2_next = asr(r2_reg + asr(acc_reg, 5'd16) + 32'd2, 5'd2); // x3
                state_next = S_P7;
            end
            S_P7:
            begin
                ma = ac4; mb = r2_reg + B4_BIAS;
                acc_next = mprod[31:0];
                state_next = S_P8;
            end
            S_P8:
            begin
                r2_next = acc_reg >> 15;            // b4
                r1_next = r3_reg;                   // b3
                state_next = S_P9;
            end
            S_P9:
            begin
                ma = up_reg - r1_reg; mb = B7_SCALE >> oss_reg;
                acc_next = mprod[31:0];             // b7
                state_next = S_P10;
            end
            S_P10:
            begin
                if (r2_reg == 32'd0)
                begin
                    val_next = '0; err_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    dreq.start = 1'b1;
                    neg_next   = acc_reg[31];
                    dreq.num   = acc_reg[31] ? acc_reg : {acc_reg[30:0], 1'b0};
                    dreq.den   = r2_reg;
                    state_next = S_PW;
                end
            end
            S_PW:
            begin
                if (drsp.done)
                begin
                    r3_next = neg_reg ? {drsp.quo[30:0], 1'b0} : drsp.quo; // p
                    state_next = S_P11;
                end
            end
            S_P11:
            begin
                ma = asr(r3_reg, 5'd8); mb = asr(r3_reg, 5'd8);
                acc_next = mprod[31:0];
                state_next = S_P12;
            end
            S_P12:
            begin
                ma = acc_reg; mb = P_C1;
                acc_next = mprod[31:0];
                state_next = S_P13;
            end
            S_P13:
            begin
                r0_next = asr(acc_reg, 5'd16);      // x1
                ma = P_C2_NEG; mb = r3_reg;
                acc_next = mprod[31:0];
                state_next = S_P14;
            end
            S_P14:
            begin
                r1_next = r0_reg + asr(acc_reg, 5'd16) + P_C3;
                state_next = S_P15;
            end
            S_P15:
            begin
                val_next = r3_reg + asr(r1_reg, 5'd4);
                err_next = 1'b0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hand the result to the output register once it is free
                if (!ov_reg || !out_stall)
                begin
                    ov_next       = 1'b1;
                    res_kind_next = kind_reg;
                    res_val_next  = val_reg;
                    res_err_next  = err_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            b5_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            b5_reg    <= b5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        up_reg       <= up_next;
        acc_reg      <= acc_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        r2_reg       <= r2_next;
        r3_reg       <= r3_next;
        neg_reg      <= neg_next;
        val_reg      <= val_next;
        err_reg      <= err_next;
        res_kind_reg <= res_kind_next;
        res_val_reg  <= res_val_next;
        res_err_reg  <= res_err_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign result_kind  = res_kind_reg;
    assign true_value   = res_val_reg;
    assign divide_error = res_err_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_error |-> true_value == 32'd0)
        else $error("error result not zero");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(true_value))
        else $error("result lost under stall");
    a_b5_temp_only: assert property (@(posedge clk) disable iff (!rst_n)
        b5_reg != $past(b5_reg) |-> $past(state_reg) == S_T3)
        else $error("b5 changed outside temperature path");
`endif

endmodule

FILE: bench/tb_barometer_reading_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometer_reading_compensation: self-checking bench for the compensation block
// Drives temperature and pressure readings under several calibration sets
// and oversampling settings. A bit-accurate predictor computes each expected
// result, and a monitor compares the results in order.
// ----------------------------------------------------------------------------
module tb_barometer_reading_compensation;
    import brc_pkg::*;

    localparam logic [2:0] CFG_IDX_SPARE = 3'd6;    // no register behind it
    localparam logic [2:0] CFG_IDX_LAST  = 3'd7;    // no register behind it
    localparam logic       KIND_TEMP     = 1'b0;
    localparam logic       KIND_PRES     = 1'b1;
    localparam int         DRAIN_CYCLES  = 80;      // beyond the slowest pressure item
    localparam int         CYCLE_LIMIT   = 1000000;

    typedef struct {
        logic        kind;
        logic [31:0] value;
        logic        err;
    } comp_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [18:0] raw_reading;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic [31:0] true_value;
    logic        divide_error;

    // predictor copy of the block's registers and kept B5
    logic [31:0]  cal_regs [0:4];
    logic [1:0]   oss_setting;
    logic [31:0]  kept_b5;
    comp_result_t pending_results [$];

    int  n_fail;
    int  n_temp;
    int  n_pres;
    int  n_diverr;
    int  hold_left;
    bit  calm;
    int  cycle_cnt;

    barometer_reading_compensation u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .raw_reading  (raw_reading),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .true_value   (true_value),
        .divide_error (divide_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // arithmetic helpers, all 32-bit wrapping
    // ------------------------------------------------------------------
    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'b0, a} * {32'b0, b};
        return p[31:0];
    endfunction

    // truncating signed divide done on magnitudes, so that the most negative
    // numerator over -1 wraps instead of overflowing
    function automatic logic [31:0] sdiv32(input logic [31:0] n, input logic [31:0] d);
        logic [31:0] un;
        logic [31:0] ud;
        logic [31:0] q;
        un = n[31] ? -n : n;
        ud = d[31] ? -d : d;
        q  = un / ud;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    // ------------------------------------------------------------------
    // predictor: compensate one reading, update kept B5
    // ------------------------------------------------------------------
    function automatic comp_result_t compensate(input logic k, input logic [18:0] raw);
        comp_result_t r;
        logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, ph;
        r.kind  = k;
        r.value = 32'd0;
        r.err   = 1'b0;
        if (k == KIND_TEMP)
        begin
            x1  = sra(mul32({16'b0, raw[15:0]} - {16'b0, cal_regs[REG_AC5_AC6][15:0]},
                            {16'b0, cal_regs[REG_AC5_AC6][31:16]}), 15);
            den = x1 + ext16(cal_regs[REG_MC_MD][15:0]);
            if (den == 32'd0)
                r.err = 1'b1;
            else
            begin
                b5      = x1 + sdiv32(ext16(cal_regs[REG_MC_MD][31:16]) << 11, den);
                kept_b5 = b5;
                r.value = sra(b5 + 32'd8, 4);
            end
        end
        else
        begin
            b6 = kept_b5 - 32'd4000;
            sq = sra(mul32(b6, b6), 12);
            x1 = sra(mul32(ext16(cal_regs[REG_B1_B2][15:0]), sq), 11);
            x2 = sra(mul32(ext16(cal_regs[REG_AC1_AC2][15:0]), b6), 11);
            x3 = x1 + x2;
            b3 = sra(((mul32(ext16(cal_regs[REG_AC1_AC2][31:16]), 32'd4) + x3)
                      << oss_setting) + 32'd2, 2);
            x1 = sra(mul32(ext16(cal_regs[REG_AC3_AC4][31:16]), b6), 13);
            x2 = sra(mul32(ext16(cal_regs[REG_B1_B2][31:16]), sq), 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = mul32({16'b0, cal_regs[REG_AC3_AC4][15:0]}, x3 + 32'd32768) >> 15;
            b7 = mul32({13'b0, raw} - b3, 32'd50000 >> oss_setting);
            if (b4 == 32'd0)
                r.err = 1'b1;
            else
            begin
                if (b7 < 32'h8000_0000)
                    p = (b7 << 1) / b4;
                else
                    p = (b7 / b4) << 1;
                ph = sra(p, 8);
                x1 = sra(mul32(mul32(ph, ph), 32'd3038), 16);
                x2 = sra(mul32(-32'd7357, p), 16);
                p  = p + sra(x1 + x2 + 32'd3791, 4);
                r.value = p;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // idle and stall shaping
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // long receiver hold-off, counted here on its own
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_left > 0)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            // start a stall burst: mostly short, now and then long
            out_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // result monitor: compare each transaction with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        comp_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d value %0d", result_kind,
                       $signed(true_value));
                n_fail++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (result_kind !== e.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", e.kind, result_kind);
                    n_fail++;
                end
                if (true_value !== e.value)
                begin
                    $error("true_value: expected %0d, got %0d", $signed(e.value),
                           $signed(true_value));
                    n_fail++;
                end
                if (divide_error !== e.err)
                begin
                    $error("divide_error: expected %0d, got %0d", e.err, divide_error);
                    n_fail++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // shared driving tasks
    // ------------------------------------------------------------------
    // Offer one reading, hold it until accepted, then predict its result.
    task automatic send_reading(input logic k, input logic [18:0] raw);
        comp_result_t r;
        int gap;
        kind        <= k;
        raw_reading <= raw;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        r = compensate(k, raw);
        pending_results.push_back(r);
        if (k == KIND_TEMP)
            n_temp++;
        else
            n_pres++;
        if (r.err)
            n_diverr++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, drain all results, then let the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_AC1_AC2, REG_AC3_AC4, REG_AC5_AC6, REG_B1_B2, REG_MC_MD:
                cal_regs[idx] = d;
            REG_OSS:
                oss_setting = d[1:0];
            default: ;
        endcase
    endtask

    task automatic load_cal(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                            input logic [31:0] d, input logic [31:0] e,
                            input logic [31:0] o);
        write_reg(REG_AC1_AC2, a);
        write_reg(REG_AC3_AC4, b);
        write_reg(REG_AC5_AC6, c);
        write_reg(REG_B1_B2, d);
        write_reg(REG_MC_MD, e);
        write_reg(REG_OSS, o);
    endtask

    task automatic load_defaults();
        load_cal(32'd26804152, 32'd3352395749, 32'd2146785905,
                 32'd405667844, 32'd3724086068, 32'd0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // Reset values: pressure first with B5 still zero, then reading extremes.
    task automatic test_reset_state();
        send_reading(KIND_PRES, 19'd0);
        send_reading(KIND_PRES, 19'h7FFFF);
        send_reading(KIND_TEMP, 19'd0);
        send_reading(KIND_TEMP, 19'h0FFFF);
        send_reading(KIND_TEMP, 19'h7FFFF);   // upper bits ignored for temperature
        send_reading(KIND_TEMP, 19'd27898);
        send_reading(KIND_PRES, 19'd23843);
    endtask

    // Every oversampling setting, ending on the maximum.
    task automatic test_oversampling();
        for (int o = 0; o < 4; o++)
        begin
            wait_idle();
            write_reg(REG_OSS, o);
            send_reading(KIND_PRES, 19'd0);
            send_reading(KIND_PRES, 19'h7FFFF);
            send_reading(KIND_PRES, 19'd23843 << o);
        end
    endtask

    // Zero divisors in both formulas; B5 must survive a failed temperature.
    task automatic test_zero_divisor();
        wait_idle();
        load_cal(32'd26804152, 32'hC7D1_0000, 32'h0000_5E1D,
                 32'd405667844, 32'h1234_0000, 32'd1);
        write_reg(CFG_IDX_SPARE, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_LAST, 32'hFFFF_FFFF);
        send_reading(KIND_TEMP, 19'd27898);   // x1 zero and MD zero
        send_reading(KIND_PRES, 19'd23843);   // AC4 zero
        wait_idle();
        load_defaults();
    endtask

    // Calibration extremes: all zeros, all ones, most negative halves.
    task automatic test_cal_extremes();
        logic [31:0] pats [0:2];
        pats = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_8000};
        foreach (pats[i])
        begin
            wait_idle();
            load_cal(pats[i], pats[i], pats[i], pats[i], pats[i], pats[i]);
            send_reading(KIND_TEMP, 19'h0FFFF);
            send_reading(KIND_PRES, 19'h7FFFF);
            send_reading(KIND_TEMP, 19'd1);
            send_reading(KIND_PRES, 19'd1);
        end
        wait_idle();
        load_defaults();
    endtask

    // Receiver holds off while readings keep coming.
    task automatic test_backpressure();
        hold_left = 400;
        for (int i = 0; i < 8; i++)
            send_reading(1'($urandom_range(0, 1)), 19'($urandom_range(0, 19'h7FFFF)));
    endtask

    // Random phases: realistic readings mostly, full-range noise otherwise.
    task automatic test_random(input int n_phases, input int per_phase);
        logic [18:0] raw;
        logic        k;
        for (int ph = 0; ph < n_phases; ph++)
        begin
            wait_idle();
            if (ph % 3 == 0)
                load_defaults();
            else
                load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            write_reg(REG_OSS, ph % 4);
            calm = (ph % 4 == 1);
            for (int i = 0; i < per_phase; i++)
            begin
                k = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 3) != 0)
                    raw = (k == KIND_TEMP) ? 19'($urandom_range(20000, 36000))
                                           : 19'($urandom_range(15000, 45000) << oss_setting);
                else
                    raw = 19'($urandom_range(0, 19'h7FFFF));
                send_reading(k, raw);
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = 3'd0;
        cfg_data    = 32'd0;
        in_valid    = 1'b0;
        kind        = 1'b0;
        raw_reading = 19'd0;
        hold_left   = 0;
        calm        = 1'b0;
        cycle_cnt   = 0;
        n_fail      = 0;
        n_temp      = 0;
        n_pres      = 0;
        n_diverr    = 0;
        cal_regs    = '{32'd26804152, 32'd3352395749, 32'd2146785905,
                        32'd405667844, 32'd3724086068};
        oss_setting = 2'd0;
        kept_b5     = 32'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_oversampling();
        test_zero_divisor();
        test_cal_extremes();
        test_backpressure();
        test_random(6, 145);

        wait_idle();
        $display("covered %0d temperature and %0d pressure readings, %0d zero divisors,",
                 n_temp, n_pres, n_diverr);
        $display("all four oversampling settings and default, random and extreme calibration");
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
